// ===== design/dpc_pkg.sv =====
`timescale 1ns / 1ps
package dpc_pkg;
    localparam int MAX_DIM_DEF = 4096;
    localparam int DISP_W = 16;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIM_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_BASELINE = 3'd0,
        REG_INV_FOCAL_X = 3'd1,
        REG_INV_FOCAL_Y = 3'd2,
        REG_MIN_DISPARITY = 3'd3,
        REG_MAX_DISPARITY = 3'd4,
        REG_IMAGE_WIDTH = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV = 2'd1,
        ST_MUL = 2'd2,
        ST_DONE = 2'd3
    } t_state;

    localparam logic [31:0] RST_FOCAL_BASELINE = 32'd5719860;
    localparam logic [31:0] RST_INV_FOCAL_X = 32'd5019432;
    localparam logic [31:0] RST_INV_FOCAL_Y = 32'd5008422;
    localparam logic [15:0] RST_MIN_DISPARITY = 16'sd0;
    localparam logic [15:0] RST_MAX_DISPARITY = 16'd32767;
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH = 13'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
endpackage

// ===== design/disparity_to_point_cloud_unit.sv =====
`timescale 1ns / 1ps
// Disparity to point cloud: each accepted disparity pixel yields one transaction with raw
// depth Z = focal_baseline*16/|d| (saturated), gated depth and x/y coordinates scaled by
// the reciprocal focal lengths. The back part takes one pixel at a time: it takes the job,
// runs the bit-serial 36-bit divider, then the shared 32x32 multiplier sequence, and presents
// the result until it is taken; only then does it accept the next job.
// The front part counts columns and rows and buffers up to four pixels in a queue.
module disparity_to_point_cloud_unit #(
    parameter int MAX_DIM = dpc_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [15:0]                  i_disparity,
    input  logic                                i_frame_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [31:0]                         o_depth_raw,
    output logic signed [31:0]                  o_point_x,
    output logic signed [31:0]                  o_point_y,
    output logic [31:0]                         o_point_z,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dpc_pkg::*;
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int JOB_W = 16 + 1 + 1 + 2 * (CNT_W + 2);

    // configuration registers
    logic [31:0] r_focal_baseline, r_inv_focal_x, r_inv_focal_y;
    logic signed [15:0] r_min_disparity, r_max_disparity;
    logic [DIM_W-1:0] r_image_width, r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_baseline <= RST_FOCAL_BASELINE;
            r_inv_focal_x <= RST_INV_FOCAL_X;
            r_inv_focal_y <= RST_INV_FOCAL_Y;
            r_min_disparity <= RST_MIN_DISPARITY;
            r_max_disparity <= RST_MAX_DISPARITY;
            r_image_width <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_FOCAL_BASELINE: r_focal_baseline <= i_cfg_data;
                REG_INV_FOCAL_X:    r_inv_focal_x <= i_cfg_data;
                REG_INV_FOCAL_Y:    r_inv_focal_y <= i_cfg_data;
                REG_MIN_DISPARITY:  r_min_disparity <= i_cfg_data[15:0];
                REG_MAX_DISPARITY:  r_max_disparity <= i_cfg_data[15:0];
                REG_IMAGE_WIDTH:    r_image_width <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   r_image_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // job queue between counting front and arithmetic back
    logic job_valid, job_ready;
    logic [JOB_W-1:0] job;

    dpc_front #(.MAX_DIM(MAX_DIM), .CNT_W(CNT_W), .JOB_W(JOB_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_disparity(i_disparity), .i_frame_start(i_frame_start),
        .i_min_disparity(r_min_disparity), .i_max_disparity(r_max_disparity),
        .i_image_width(r_image_width), .i_image_height(r_image_height),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    dpc_back #(.MAX_DIM(MAX_DIM), .CNT_W(CNT_W), .JOB_W(JOB_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .i_focal_baseline(r_focal_baseline),
        .i_inv_focal_x(r_inv_focal_x), .i_inv_focal_y(r_inv_focal_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_depth_raw(o_depth_raw), .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_z(o_point_z), .o_frame_last(o_frame_last)
    );
endmodule

// ===== design/dpc_front.sv =====
`timescale 1ns / 1ps
// front: pixel counters and range check, pushes one job per pixel to a fifo
module dpc_front #(
    parameter int MAX_DIM = dpc_pkg::MAX_DIM_DEF,
    parameter int CNT_W = $clog2(MAX_DIM),
    parameter int JOB_W = 16 + 1 + 1 + 2 * (CNT_W + 2)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [15:0]           i_disparity,
    input  logic                         i_frame_start,
    input  logic signed [15:0]           i_min_disparity,
    input  logic signed [15:0]           i_max_disparity,
    input  logic [dpc_pkg::DIM_W-1:0]    i_image_width,
    input  logic [dpc_pkg::DIM_W-1:0]    i_image_height,
    output logic                         o_job_valid,
    input  logic                         i_job_ready,
    output logic [JOB_W-1:0]             o_job
);
    import dpc_pkg::*;
    localparam int EW = $clog2(MAX_DIM + 1);
    localparam int OW = CNT_W + 2;

    logic [CNT_W-1:0] r_col, r_row, n_col, n_row, w_col, w_row;
    logic [EW-1:0] w_eff, h_eff;
    logic [OW-1:0] off_x, off_y;
    logic in_range, last_c, last_r;

    function automatic logic [EW-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [EW-1:0] v;
        if (r == '0) v = EW'(1);
        else if (32'(r) > MAX_DIM) v = EW'(MAX_DIM);
        else v = EW'(r);
        return v;
    endfunction

    // queue between front and back
    logic [JOB_W-1:0] r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 3'd4);
    assign push = i_valid && o_ready;
    assign pop = o_job_valid && i_job_ready;
    assign o_job_valid = (r_cnt != 3'd0);
    assign o_job = r_q[r_rp];

    always_comb begin
        w_eff = eff_dim(i_image_width);
        h_eff = eff_dim(i_image_height);
        w_col = i_frame_start ? '0 : r_col;
        w_row = i_frame_start ? '0 : r_row;
        last_c = ({1'b0, w_col} >= (EW+1)'(w_eff - 1'b1));
        last_r = ({1'b0, w_row} >= (EW+1)'(h_eff - 1'b1));
        off_x = OW'({2'b00, w_col}) - OW'(w_eff >> 1);
        off_y = OW'({2'b00, w_row}) - OW'(h_eff >> 1);
        in_range = !(i_disparity < i_min_disparity) && !(i_disparity > i_max_disparity);
        if (last_c) begin
            n_col = '0;
            n_row = last_r ? '0 : w_row + 1'b1;
        end else begin
            n_col = w_col + 1'b1;
            n_row = w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_col <= n_col;
                r_row <= n_row;
                r_wp <= r_wp + 1'b1;
            end
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= {i_disparity, in_range, last_c && last_r, off_x, off_y};
    end
endmodule

// ===== design/dpc_back.sv =====
`timescale 1ns / 1ps
// back: serial divider for depth, then shared 32x32 multiplier for x and y
module dpc_back #(
    parameter int MAX_DIM = dpc_pkg::MAX_DIM_DEF,
    parameter int CNT_W = $clog2(MAX_DIM),
    parameter int JOB_W = 16 + 1 + 1 + 2 * (CNT_W + 2)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  logic [JOB_W-1:0]      i_job,
    input  logic [31:0]           i_focal_baseline,
    input  logic [31:0]           i_inv_focal_x,
    input  logic [31:0]           i_inv_focal_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [31:0]           o_depth_raw,
    output logic signed [31:0]    o_point_x,
    output logic signed [31:0]    o_point_y,
    output logic [31:0]           o_point_z,
    output logic                  o_frame_last
);
    import dpc_pkg::*;
    localparam int OW = CNT_W + 2;

    t_state r_state, n_state;
    logic r_inr, r_last;
    logic signed [OW-1:0] r_ox, r_oy;
    logic [35:0] r_num;     // shifted dividend / quotient
    logic [16:0] r_rem;
    logic [16:0] r_den;
    logic [5:0] r_step;
    logic [31:0] r_z, r_zg;
    logic [63:0] r_tx, r_ty;
    logic [2:0] r_mstep;
    logic [63:0] r_pa, r_pb;
    logic [31:0] r_mx, r_my;

    logic [17:0] trial;
    logic [OW-1:0] ox_u, oy_u;
    logic [63:0] prod;
    logic [31:0] mul_a, mul_b;

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_depth_raw = r_z;
    assign o_point_z = r_zg;
    assign o_point_x = r_mx;
    assign o_point_y = r_my;
    assign o_frame_last = r_last;

    assign trial = {r_rem, r_num[35]} - {1'b0, r_den};
    assign ox_u = r_ox[OW-1] ? -r_ox : r_ox;
    assign oy_u = r_oy[OW-1] ? -r_oy : r_oy;

    // mstep: 0 tx=zg*invx, 1 ty=zg*invy, 2 a*tx_hi, 3 a*tx_lo, 4 a*ty_hi, 5 a*ty_lo
    always_comb begin
        unique case (r_mstep)
            3'd0: begin mul_a = r_zg; mul_b = i_inv_focal_x; end
            3'd1: begin mul_a = r_zg; mul_b = i_inv_focal_y; end
            3'd2: begin mul_a = 32'(ox_u); mul_b = r_tx[63:32]; end
            3'd3: begin mul_a = 32'(ox_u); mul_b = r_tx[31:0]; end
            3'd4: begin mul_a = 32'(oy_u); mul_b = r_ty[63:32]; end
            3'd5: begin mul_a = 32'(oy_u); mul_b = r_ty[31:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_DIV;
            ST_DIV:  if (r_step == 6'd36) n_state = ST_MUL;
            ST_MUL:  if (r_mstep == 3'd7) n_state = ST_DONE;
            ST_DONE: if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    function automatic logic [31:0] sat(input logic neg, input logic [63:0] mag);
        logic [31:0] v;
        if (neg) v = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0 - mag);
        else v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                {r_inr, r_last, r_ox, r_oy} <= i_job[JOB_W-17:0];
                r_num <= {i_focal_baseline, 4'b0000};
                r_rem <= '0;
                r_den <= i_job[JOB_W-1] ? {1'b0, 16'(~i_job[JOB_W-1 -: 16] + 16'd1)}
                                        : {1'b0, i_job[JOB_W-1 -: 16]};
                r_step <= '0;
                r_mstep <= '0;
            end
            ST_DIV: begin
                if (r_step < 6'd36) begin
                    if (!trial[17]) begin
                        r_rem <= trial[16:0];
                        r_num <= {r_num[34:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[15:0], r_num[35]};
                        r_num <= {r_num[34:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                end else begin
                    // zero disparity or quotient overflow saturates
                    r_z <= (r_den == '0 || r_num[35:32] != '0) ? 32'hFFFF_FFFF : r_num[31:0];
                    r_zg <= !r_inr ? 32'd0 :
                        ((r_den == '0 || r_num[35:32] != '0) ? 32'hFFFF_FFFF : r_num[31:0]);
                    r_step <= '0;
                end
            end
            ST_MUL: begin
                case (r_mstep)
                    3'd0: r_tx <= prod;
                    3'd1: r_ty <= prod;
                    3'd2: r_pa <= prod;
                    3'd3: r_pa <= r_pa + 64'(prod[63:32]);
                    3'd4: r_pb <= prod;
                    3'd5: r_pb <= r_pb + 64'(prod[63:32]);
                    3'd6: r_mx <= sat(r_ox[OW-1], r_pa);
                    3'd7: r_my <= sat(r_oy[OW-1], r_pb);
                    default: ;
                endcase
                r_mstep <= r_mstep + 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ===== design/dpc_checker.sv =====
`timescale 1ns / 1ps
module dpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_depth_raw,
    input logic [31:0] o_point_z
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_depth_raw)) else $error("output dropped");
    a_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_point_z == 32'd0) || (o_point_z == o_depth_raw))
        else $error("gated depth mismatch");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid) else $error("result repeated");
endmodule

bind disparity_to_point_cloud_unit dpc_checker u_dpc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_depth_raw(o_depth_raw), .o_point_z(o_point_z)
);

// ===== tb/tb_disparity_to_point_cloud_unit.sv =====
`timescale 1ns / 1ps
module tb_disparity_to_point_cloud_unit;
    import dpc_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [31:0] depth_raw;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic        frame_last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic signed [15:0] i_disparity = '0;
    logic        i_frame_start = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_depth_raw;
    logic signed [31:0] o_point_x;
    logic signed [31:0] o_point_y;
    logic [31:0] o_point_z;
    logic        o_frame_last;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow copy of the registers and the raster position
    logic [31:0] focal_baseline_q, inv_fx_q, inv_fy_q;
    logic [15:0] min_disp_q, max_disp_q;
    logic [12:0] width_q, height_q;
    int unsigned col_q, row_q;

    t_point pending_points[$];
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned points_checked = 0;
    int unsigned pixels_sent = 0;
    int unsigned frame_lasts_seen = 0;

    disparity_to_point_cloud_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d points outstanding",
                cycle_count, pending_points.size());
            $display("disparity_to_point_cloud_unit regression: fail");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(logic [12:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
        return r;
    endfunction

    // off * z * inv >> 32 with the magnitude truncated, saturated to signed 32
    function automatic logic [31:0] reproject(int off, logic [31:0] z, logic [31:0] inv);
        logic [63:0] prod;
        logic [63:0] mag_off;
        logic [63:0] mag;
        prod = 64'(z) * 64'(inv);
        mag_off = (off < 0) ? 64'(-off) : 64'(off);
        mag = mag_off * prod[63:32] + ((mag_off * prod[31:0]) >> 32);
        if (off < 0) begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return -mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // predicted point for one pixel; advances the raster position
    function automatic t_point predict_point(logic signed [15:0] disp, logic start);
        t_point p;
        int unsigned w, h, col, row, mag_d;
        logic [63:0] quot;
        logic [31:0] z, zg;
        w = clamp_dim(width_q);
        h = clamp_dim(height_q);
        if (start) begin
            col_q = 0;
            row_q = 0;
        end
        col = col_q;
        row = row_q;
        mag_d = (disp < 0) ? -int'(disp) : int'(disp);
        if (mag_d == 0) begin
            z = '1;
        end else begin
            quot = {28'd0, focal_baseline_q, 4'd0} / 64'(mag_d);
            z = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
        end
        zg = z;
        if (disp < $signed(min_disp_q) || disp > $signed(max_disp_q)) zg = '0;
        p.depth_raw = z;
        p.point_x = reproject(int'(col) - int'(w / 2), zg, inv_fx_q);
        p.point_y = reproject(int'(row) - int'(h / 2), zg, inv_fy_q);
        p.point_z = zg;
        p.frame_last = (col >= w - 1) && (row >= h - 1);
        if (col >= w - 1) begin
            col_q = 0;
            row_q = (row >= h - 1) ? 0 : row + 1;
        end else begin
            col_q = col + 1;
        end
        return p;
    endfunction

    // result checker: compare every accepted transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_point got, exp_p;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_depth_raw, o_point_x, o_point_y, o_point_z, o_frame_last};
            if (pending_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: %p", got);
            end else begin
                exp_p = pending_points.pop_front();
                points_checked++;
                if (got.frame_last) frame_lasts_seen++;
                if (got !== exp_p) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch on point %0d", points_checked);
                        $display("  expected z=%h x=%h y=%h zg=%h last=%b", exp_p.depth_raw,
                            exp_p.point_x, exp_p.point_y, exp_p.point_z, exp_p.frame_last);
                        $display("  actual   z=%h x=%h y=%h zg=%h last=%b", got.depth_raw,
                            got.point_x, got.point_y, got.point_z, got.frame_last);
                    end
                end
            end
        end
    end

    // receiver: random stall before each transaction
    bit sink_stalls = 1'b1;
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = sink_stalls ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk iff o_valid);
        end
    end

    bit source_gaps = 1'b1;

    // one pixel transaction; the prediction is made at acceptance
    task automatic send_pixel(logic signed [15:0] disp, logic start);
        int gap;
        t_point exp_p;
        gap = source_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_disparity <= disp;
        i_frame_start <= start;
        @(posedge i_clk iff o_ready);
        exp_p = predict_point(disp, start);
        pending_points = {pending_points, exp_p};
        pixels_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FOCAL_BASELINE: focal_baseline_q = value;
            REG_INV_FOCAL_X:    inv_fx_q = value;
            REG_INV_FOCAL_Y:    inv_fy_q = value;
            REG_MIN_DISPARITY:  min_disp_q = value[15:0];
            REG_MAX_DISPARITY:  max_disp_q = value[15:0];
            REG_IMAGE_WIDTH:    width_q = value[12:0];
            REG_IMAGE_HEIGHT:   height_q = value[12:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [31:0] fb, logic [31:0] ifx, logic [31:0] ify,
                                logic [15:0] dmin, logic [15:0] dmax,
                                logic [12:0] w, logic [12:0] h);
        write_reg(REG_FOCAL_BASELINE, fb);
        write_reg(REG_INV_FOCAL_X, ifx);
        write_reg(REG_INV_FOCAL_Y, ify);
        write_reg(REG_MIN_DISPARITY, {16'd0, dmin});
        write_reg(REG_MAX_DISPARITY, {16'd0, dmax});
        write_reg(REG_IMAGE_WIDTH, {19'd0, w});
        write_reg(REG_IMAGE_HEIGHT, {19'd0, h});
    endtask

    // mostly realistic disparities, some anywhere in the 16-bit range
    function automatic logic signed [15:0] rand_disp();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'sd0;
            2: return -16'sd32768;
            3: return -16'($urandom_range(1, 2000));
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    // extremes at reset settings: zero and both ends; then quotient overflow with a large focal_baseline
    task automatic test_directed_extremes();
        send_pixel(16'sd0, 1'b1);
        send_pixel(16'sd1, 1'b0);
        send_pixel(-16'sd1, 1'b0);
        send_pixel(16'sd32767, 1'b0);
        send_pixel(-16'sd32768, 1'b0);
        send_pixel(16'sh5555, 1'b0);
        send_pixel(16'shAAAA, 1'b0);
        send_pixel(16'sd100, 1'b1);
        wait_idle();
        // large focal_baseline overflows even mid-range quotients
        set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd32768, 16'sd32767,
                     13'd2, 13'd2);
        send_pixel(16'sd1, 1'b1);
        send_pixel(16'sd15, 1'b0);
        send_pixel(16'sd16, 1'b0);
        send_pixel(-16'sd17, 1'b0);
        send_pixel(16'sd0, 1'b0);
        send_pixel(-16'sd32768, 1'b0);
        wait_idle();
    endtask

    // min above max: every pixel out of range; zero sizes clamp to one; then min equal to max on a 1x3 image
    task automatic test_empty_range_and_tiny_image();
        set_geometry(32'd0, 32'd0, 32'd0, 16'sd100, -16'sd100, 13'd0, 13'd0);
        send_pixel(16'sd0, 1'b0);
        send_pixel(16'sd50, 1'b0);
        send_pixel(-16'sd50, 1'b1);
        wait_idle();
        set_geometry(32'd5719860, 32'd5019432, 32'd5008422, 16'sd16, 16'sd16,
                     13'd1, 13'd3);
        send_pixel(16'sd16, 1'b1);
        send_pixel(16'sd17, 1'b0);
        send_pixel(16'sd15, 1'b0);
        send_pixel(16'sd16, 1'b0);
        wait_idle();
    endtask

    // sizes above the maximum clamp; size shrinks mid-frame leave counters past the end
    task automatic test_size_clamp_and_shrink();
        set_geometry(32'h0100_0000, 32'h8000_0000, 32'h8000_0000, 16'sd1, 16'sd32767,
                     13'h1FFF, 13'd4097);
        send_pixel(16'sd8, 1'b1);
        for (int i = 0; i < 6; i++) send_pixel(rand_disp(), 1'b0);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 32'd3);
        write_reg(REG_IMAGE_HEIGHT, 32'd1);
        for (int i = 0; i < 4; i++) send_pixel(rand_disp(), 1'b0);
        wait_idle();
    endtask

    // random frames with random settings; frame_start mostly at frame boundaries
    task automatic test_random_frames(int unsigned n_pixels);
        int unsigned sent;
        int unsigned frame_pix, w, h;
        sent = 0;
        while (sent < n_pixels) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 8);
            set_geometry($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24),
                         $urandom, $urandom,
                         16'($urandom_range(0, 3) == 0 ? $urandom : -$urandom_range(0, 200)),
                         16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000)),
                         13'(w), 13'(h));
            source_gaps = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            frame_pix = (clamp_dim(13'(w)) * clamp_dim(13'(h)) > 40) ? 40
                        : clamp_dim(13'(w)) * clamp_dim(13'(h));
            for (int f = 0; f < 3 && sent < n_pixels; f++) begin
                for (int p = 0; p < frame_pix; p++) begin
                    send_pixel(rand_disp(), (p == 0) || ($urandom_range(0, 49) == 0));
                    sent++;
                end
            end
            // sender holds off until every point has come back
            wait_idle();
        end
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        focal_baseline_q = RST_FOCAL_BASELINE;
        inv_fx_q = RST_INV_FOCAL_X;
        inv_fy_q = RST_INV_FOCAL_Y;
        min_disp_q = RST_MIN_DISPARITY;
        max_disp_q = RST_MAX_DISPARITY;
        width_q = RST_IMAGE_WIDTH;
        height_q = RST_IMAGE_HEIGHT;
        col_q = 0;
        row_q = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_empty_range_and_tiny_image();
        test_size_clamp_and_shrink();
        test_random_frames(1520);
        wait_idle();

        $display("covered %0d pixels, %0d points checked, %0d frame ends, %0d mismatches",
            pixels_sent, points_checked, frame_lasts_seen, mismatch_count);
        $display("settings swept over extreme and random calibration, range and image size");
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("disparity_to_point_cloud_unit regression: pass");
        end else begin
            $display("disparity_to_point_cloud_unit regression: fail");
        end
        $finish;
    end
endmodule
